[design/exec_line_tokenizer_top_assert.svh]
// ---------------------------------------------------------------------------
// exec_line_tokenizer_top_assert.svh
// assertion macros for the exec line tokenizer, clocked on aclk and
// disabled while aresetn is low
// ---------------------------------------------------------------------------
`ifndef EXEC_LINE_TOKENIZER_TOP_ASSERT_SVH
`define EXEC_LINE_TOKENIZER_TOP_ASSERT_SVH

// same-cycle implication
`define ELT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error("tokenizer assertion failed");

// next-cycle implication
`define ELT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error("tokenizer assertion failed");

`endif

[design/elt_pkg.sv]
// ---------------------------------------------------------------------------
// elt_pkg
// types and character constants shared by the exec line tokenizer
// ---------------------------------------------------------------------------
package elt_pkg;

    localparam logic [15:0] CH_BSLASH = 16'h005C;
    localparam logic [15:0] CH_PCT    = 16'h0025;
    localparam logic [15:0] CH_DQUOTE = 16'h0022;
    localparam logic [15:0] CH_SQUOTE = 16'h0027;
    localparam logic [15:0] CH_SPACE  = 16'h0020;
    localparam logic [15:0] CH_LF     = 16'h000A;
    localparam logic [15:0] CH_TAB    = 16'h0009;
    localparam logic [15:0] CH_CR     = 16'h000D;
    localparam logic [15:0] CH_S      = 16'h0073;
    localparam logic [15:0] CH_N      = 16'h006E;
    localparam logic [15:0] CH_T      = 16'h0074;
    localparam logic [15:0] CH_R      = 16'h0072;

    // a backslash arriving at this run count inside quotes is the fourth of a run and gives one backslash
    localparam logic [2:0]  ESC_LAST  = 3'd3;

    typedef struct packed {
        logic [15:0] chr;
        logic        last;
    } elt_in_t;

    typedef struct packed {
        logic [15:0] out_char;
        logic        char_valid;
        logic        arg_end;
    } elt_out_t;

    typedef struct packed {
        logic [2:0] escape_count;
        logic       in_quote;
        logic       percent_pending;
        logic       arg_nonempty;
    } elt_state_t;

    function automatic logic [15:0] quoted_escape(input logic [15:0] c);
        logic [15:0] r;
        unique case (c)
            CH_S:    r = CH_SPACE;
            CH_N:    r = CH_LF;
            CH_T:    r = CH_TAB;
            CH_R:    r = CH_CR;
            default: r = c;
        endcase
        return r;
    endfunction

endpackage

[design/elt_decode.sv]
// ---------------------------------------------------------------------------
// elt_decode
// per-character tokenizer step: next state and the optional result
// ---------------------------------------------------------------------------
module elt_decode
    import elt_pkg::*;
(
    input  elt_in_t    item,
    input  elt_state_t state,
    output elt_state_t state_next,
    output elt_out_t   result,
    output logic       has_result
);

    logic        emit;
    logic        close;
    logic [15:0] ch;
    logic        is_quote;
    logic        is_bslash;
    elt_state_t  ns;

    assign is_quote  = (item.chr == CH_DQUOTE) || (item.chr == CH_SQUOTE);
    assign is_bslash = (item.chr == CH_BSLASH);

    always_comb begin
        ns    = state;
        emit  = 1'b0;
        close = 1'b0;
        ch    = '0;
        priority if (state.escape_count == 3'd0 && is_bslash) begin
            ns.escape_count = 3'd1;
        end else if (state.in_quote) begin
            priority if (is_bslash) begin
                if (state.escape_count >= ESC_LAST) begin
                    emit            = 1'b1;
                    ch              = CH_BSLASH;
                    ns.escape_count = 3'd0;
                end else begin
                    ns.escape_count = state.escape_count + 3'd1;
                end
            end else if (state.escape_count == 3'd2) begin
                emit            = 1'b1;
                ch              = item.chr;
                ns.escape_count = 3'd0;
            end else if (state.escape_count != 3'd0) begin
                emit            = 1'b1;
                ch              = quoted_escape(item.chr);
                ns.escape_count = 3'd0;
            end else if (is_quote) begin
                ns.in_quote = 1'b0;
            end else begin
                emit = 1'b1;
                ch   = item.chr;
            end
        end else if (state.escape_count != 3'd0) begin
            // literal pass-through outside quotes
            emit            = 1'b1;
            ch              = item.chr;
            ns.escape_count = 3'd0;
        end else if (state.percent_pending) begin
            if (item.chr == CH_PCT) begin
                emit = 1'b1;
                ch   = CH_PCT;
            end
            ns.percent_pending = 1'b0;
        end else if (item.chr == CH_PCT) begin
            ns.percent_pending = 1'b1;
        end else if (is_quote) begin
            ns.in_quote = 1'b1;
        end else if (item.chr == CH_SPACE) begin
            if (state.arg_nonempty) begin
                close           = 1'b1;
                ns.arg_nonempty = 1'b0;
            end
        end else begin
            emit = 1'b1;
            ch   = item.chr;
        end

        if (emit) begin
            ns.arg_nonempty = 1'b1;
        end

        // end of string closes any open argument and restarts
        if (item.last) begin
            if (ns.arg_nonempty) begin
                close = 1'b1;
            end
            ns = '0;
        end
    end

    assign state_next        = ns;
    assign has_result        = emit || close;
    assign result.out_char   = emit ? ch : 16'h0000;
    assign result.char_valid = emit;
    assign result.arg_end    = close;

endmodule

[design/exec_line_tokenizer_top.sv]
// ---------------------------------------------------------------------------
// exec_line_tokenizer_top
// splits a command line, one 16-bit code unit per transfer, into arguments
// ---------------------------------------------------------------------------
// channel   ports                      payload
// input     s_valid s_ready s_data     elt_in_t  {chr, last}
// result    m_valid m_ready m_data     elt_out_t {out_char, char_valid, arg_end}
//
// one character per cycle sustained while m_ready holds; a result passes from the input
// register through the decode into the result register, which loads when free or draining
// only the combinational decode between the two registers touches the tokenizer state
// characters that produce nothing leave no result transfer
// aresetn (synchronous) clears both valid flags and the tokenizer state
// a stall on m_ready holds the result register, then the input register
// ---------------------------------------------------------------------------
`include "exec_line_tokenizer_top_assert.svh"

module exec_line_tokenizer_top
    import elt_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  elt_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output elt_out_t m_data
);

    elt_in_t    in_reg;
    logic       in_valid_reg;
    elt_state_t state_reg;
    elt_state_t state_next;
    elt_out_t   out_reg;
    logic       out_valid_reg;
    elt_out_t   result;
    logic       has_result;
    logic       advance;

    // the held item moves on when the result register is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    elt_decode u_decode (
        .item       (in_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result),
        .has_result (has_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                state_reg <= state_next;
            end
            if (advance) begin
                out_valid_reg <= has_result;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && has_result) begin
            out_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    `ELT_ASSERT_IMPL(a_esc_bound, 1'b1, state_reg.escape_count <= ESC_LAST)
    `ELT_ASSERT_NEXT(a_last_restarts, advance && in_reg.last, state_reg == '0)
    `ELT_ASSERT_IMPL(a_result_nonempty, out_valid_reg, out_reg.char_valid || out_reg.arg_end)
    `ELT_ASSERT_IMPL(a_char_zero, out_valid_reg && !out_reg.char_valid,
                     out_reg.out_char == 16'h0000)
    `ELT_ASSERT_NEXT(a_input_held, in_valid_reg && !advance,
                     in_valid_reg && $stable(in_reg) && $stable(state_reg))

endmodule

[dv/exec_line_tokenizer_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// exec_line_tokenizer_checker
// watches both channels of the exec line tokenizer, predicts the result of
// every accepted character and compares each result transfer in order
// ---------------------------------------------------------------------------
module exec_line_tokenizer_checker
    import elt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  elt_in_t     s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  elt_out_t    m_data,
    output int unsigned mismatches,
    output int unsigned waiting
);

    localparam logic [2:0] ESC_NONE = 3'd0;
    localparam logic [2:0] ESC_ONE  = 3'd1;
    localparam logic [2:0] ESC_TWO  = 3'd2;
    localparam int unsigned MAX_REPORTS = 10;

    elt_state_t  line_st;
    elt_out_t    tokens_due[$];
    int unsigned err_cnt;

    // advances the tokenizer state by one character, returns 1 if a result is due
    function automatic bit split_step(input elt_in_t in, output elt_out_t tok);
        logic [15:0] c;
        logic [15:0] ch;
        bit          emit;
        bit          close;
        bit          quote_ch;
        c        = in.chr;
        ch       = '0;
        emit     = 1'b0;
        close    = 1'b0;
        quote_ch = (c == CH_DQUOTE) || (c == CH_SQUOTE);
        if (line_st.escape_count == ESC_NONE && c == CH_BSLASH) begin
            line_st.escape_count = ESC_ONE;
        end else if (line_st.in_quote) begin
            if (c == CH_BSLASH) begin
                // fourth backslash of a run gives one backslash
                if (line_st.escape_count == ESC_LAST) begin
                    emit = 1'b1;
                    ch = CH_BSLASH;
                    line_st.escape_count = ESC_NONE;
                end else begin
                    line_st.escape_count = line_st.escape_count + 3'd1;
                end
            end else if (line_st.escape_count == ESC_TWO) begin
                emit = 1'b1;
                ch = c;
                line_st.escape_count = ESC_NONE;
            end else if (line_st.escape_count != ESC_NONE) begin
                emit = 1'b1;
                line_st.escape_count = ESC_NONE;
                case (c)
                    CH_S:    ch = CH_SPACE;
                    CH_N:    ch = CH_LF;
                    CH_T:    ch = CH_TAB;
                    CH_R:    ch = CH_CR;
                    default: ch = c;
                endcase
            end else if (quote_ch) begin
                line_st.in_quote = 1'b0;
            end else begin
                emit = 1'b1;
                ch = c;
            end
        end else if (line_st.escape_count != ESC_NONE) begin
            emit = 1'b1;
            ch = c;
            line_st.escape_count = ESC_NONE;
        end else if (line_st.percent_pending) begin
            // only a second percent survives, other field codes vanish
            if (c == CH_PCT) begin
                emit = 1'b1;
                ch = CH_PCT;
            end
            line_st.percent_pending = 1'b0;
        end else if (c == CH_PCT) begin
            line_st.percent_pending = 1'b1;
        end else if (quote_ch) begin
            line_st.in_quote = 1'b1;
        end else if (c == CH_SPACE) begin
            if (line_st.arg_nonempty) begin
                close = 1'b1;
                line_st.arg_nonempty = 1'b0;
            end
        end else begin
            emit = 1'b1;
            ch = c;
        end

        if (emit) begin
            line_st.arg_nonempty = 1'b1;
        end
        if (in.last) begin
            if (line_st.arg_nonempty) begin
                close = 1'b1;
            end
            line_st = '0;
        end

        tok.out_char   = emit ? ch : '0;
        tok.char_valid = emit;
        tok.arg_end    = close;
        return emit || close;
    endfunction

    always @(posedge aclk) begin : watch
        elt_out_t want;
        elt_out_t pred;
        if (!aresetn) begin
            line_st = '0;
            tokens_due.delete();
            err_cnt = 0;
        end else begin
            if (s_valid && s_ready) begin
                if (split_step(s_data, pred)) begin
                    tokens_due.push_back(pred);
                end
            end
            if (m_valid && m_ready) begin
                if (tokens_due.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS) begin
                        $display("%0t: result transfer with none due: char %h valid %b end %b",
                                 $realtime, m_data.out_char, m_data.char_valid,
                                 m_data.arg_end);
                    end
                end else begin
                    want = tokens_due.pop_front();
                    if (m_data.out_char !== want.out_char ||
                        m_data.char_valid !== want.char_valid ||
                        m_data.arg_end !== want.arg_end) begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS) begin
                            $display({"%0t: mismatch exp char %h valid %b end %b, ",
                                      "got char %h valid %b end %b"},
                                     $realtime, want.out_char, want.char_valid, want.arg_end,
                                     m_data.out_char, m_data.char_valid, m_data.arg_end);
                        end
                    end
                end
            end
        end
        mismatches <= err_cnt;
        waiting    <= tokens_due.size();
    end

endmodule

[dv/exec_line_tokenizer_top_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// exec_line_tokenizer_top_tb
// feeds command lines to the exec line tokenizer, directed corner lines first
// and then random lines built from words, quoted runs, escapes and percent
// codes, with random gaps and stalls on both channels
// ---------------------------------------------------------------------------
module exec_line_tokenizer_top_tb;
    import elt_pkg::*;

    localparam int unsigned TOTAL_CHARS   = 1975;
    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int unsigned SETTLE_CYCLES = 20;
    localparam logic [15:0] CHR_F         = 16'h0066;
    localparam logic [15:0] CHR_MAX       = 16'hFFFF;
    localparam logic [15:0] CHR_NUL       = 16'h0000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    elt_in_t     s_data;
    logic        m_valid;
    logic        m_ready;
    elt_out_t    m_data;
    int unsigned mismatches;
    int unsigned waiting;

    int unsigned cycle_cnt = 0;
    int unsigned chars_sent;
    bit          tx_steady;
    logic [15:0] line_buf[$];

    exec_line_tokenizer_top DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    exec_line_tokenizer_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .mismatches (mismatches),
        .waiting    (waiting)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [15:0] plain_char();
        logic [15:0] c;
        if ($urandom_range(0, 3) == 0) begin
            c = 16'($urandom);
        end else begin
            c = 16'($urandom_range(16'h21, 16'h7E));
        end
        return c;
    endfunction

    // bias toward the characters the tokenizer treats specially
    function automatic logic [15:0] pick_char();
        logic [15:0] c;
        case ($urandom_range(0, 9))
            0: c = CH_BSLASH;
            1: c = CH_PCT;
            2: c = CH_DQUOTE;
            3: c = CH_SQUOTE;
            4: c = CH_SPACE;
            5: begin
                case ($urandom_range(0, 3))
                    0:       c = CH_S;
                    1:       c = CH_N;
                    2:       c = CH_T;
                    default: c = CH_R;
                endcase
            end
            6, 7:    c = 16'($urandom);
            default: c = plain_char();
        endcase
        return c;
    endfunction

    function automatic void build_line();
        logic [15:0] q;
        line_buf.delete();
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 5))
                0: repeat ($urandom_range(1, 5)) line_buf.push_back(plain_char());
                1: repeat ($urandom_range(1, 3)) line_buf.push_back(CH_SPACE);
                2: begin
                    q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
                    line_buf.push_back(q);
                    repeat ($urandom_range(0, 4)) begin
                        if ($urandom_range(0, 1)) begin
                            line_buf.push_back(plain_char());
                        end else begin
                            repeat ($urandom_range(1, 4)) line_buf.push_back(CH_BSLASH);
                            line_buf.push_back(pick_char());
                        end
                    end
                    if ($urandom_range(0, 3) != 0) begin
                        line_buf.push_back(q);
                    end
                end
                3: begin
                    line_buf.push_back(CH_PCT);
                    line_buf.push_back($urandom_range(0, 1) ? CH_PCT : pick_char());
                end
                4: begin
                    line_buf.push_back(CH_BSLASH);
                    line_buf.push_back(pick_char());
                end
                default: repeat ($urandom_range(1, 3)) line_buf.push_back(pick_char());
            endcase
        end
    endfunction

    task automatic send_char(input logic [15:0] c, input logic fin);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{chr: c, last: fin};
        do @(posedge aclk); while (!s_ready);
        chars_sent++;
        if ($urandom_range(0, 39) == 0) begin
            tx_steady = !tx_steady;
        end
    endtask

    // a stray end-of-line mark now and then breaks lines early
    task automatic send_line(input bit noisy);
        logic fin;
        for (int i = 0; i < line_buf.size(); i++) begin
            fin = (i == line_buf.size() - 1) || (noisy && $urandom_range(0, 63) == 0);
            send_char(line_buf[i], fin);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (waiting != 0) @(posedge aclk);
    endtask

    initial begin : result_sink
        int  stall;
        bit  steady;
        steady = 1'b0;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if ($urandom_range(0, 39) == 0) begin
                steady = !steady;
            end
        end
    end

    initial begin : stimulus
        bit paused;
        paused     = 1'b0;
        chars_sent = 0;
        tx_steady  = 1'b0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // quoted escapes and a four-backslash run, quote left open at the end
        line_buf = '{CH_DQUOTE, CH_BSLASH, CH_N, CH_BSLASH, CH_T, CH_BSLASH, CH_R,
                     CH_BSLASH, CH_S, CH_BSLASH, CH_BSLASH, CH_BSLASH, CH_BSLASH};
        send_line(1'b0);
        // leading space, double backslash in quotes, percent pair, dropped field
        // code, outside escape, extreme code units, space as final character
        line_buf = '{CH_SPACE, CH_SQUOTE, CH_BSLASH, CH_BSLASH, CHR_MAX, CH_SQUOTE,
                     CH_SPACE, CH_PCT, CH_PCT, CH_PCT, CHR_F, CH_BSLASH, CH_DQUOTE,
                     CHR_NUL, CH_SPACE};
        send_line(1'b0);
        // escape pending when the line ends
        line_buf = '{CH_BSLASH};
        send_line(1'b0);
        drain_results();

        while (chars_sent < TOTAL_CHARS) begin
            build_line();
            send_line(1'b1);
            if (!paused && chars_sent >= TOTAL_CHARS / 2) begin
                drain_results();
                paused = 1'b1;
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
